>>> hdl/region_handle_lru_cache_assert.svh
// Assertion macros for the region handle cache.
// Included by the top level; depends on nothing else.
`ifndef REGION_HANDLE_LRU_CACHE_ASSERT_SVH
`define REGION_HANDLE_LRU_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RHLC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("region cache assertion failed");

// Next-cycle implication, disabled during reset.
`define RHLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("region cache assertion failed");

`endif

>>> hdl/rhlc_pkg.sv
// Shared types and constants of the region handle cache.
// No dependencies.
`default_nettype none

package rhlc_pkg;

   localparam int DEF_MAX_OPEN_REGIONS = 16;
   localparam int DEF_REGION_SHIFT     = 5;

   localparam int COORD_W    = 22;
   localparam int OUTCOME_W  = 3;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 4;
   localparam int LOC_OUT_W  = 5;
   localparam int KEY_OUT_W  = 17;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // open outcome codes
   localparam logic [OUTCOME_W-1:0] OC_OPENED  = 3'd0;
   localparam logic [OUTCOME_W-1:0] OC_ABSENT  = 3'd1;
   localparam logic [OUTCOME_W-1:0] OC_NO_OPEN = 3'd2;
   localparam logic [OUTCOME_W-1:0] OC_CORRUPT = 3'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STS_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] STS_OPENED  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_ABSENT  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NO_OPEN = 3'd3;
   localparam logic [STATUS_W-1:0] STS_CORRUPT = 3'd4;
   localparam logic [STATUS_W-1:0] STS_IO_ERR  = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_UPDATE,
      ST_UPDATE_END,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> hdl/region_handle_lru_cache.sv
// Region handle cache: fully associative table of open regions, LRU order.
// Request channel req_* carries a chunk coordinate pair and the open outcome
// to apply on a miss; response channel rsp_* returns status, slot, local
// offsets and the evicted region, if any. Both use tvalid/tready handshakes.
// Keys and recency ranks live in one RAM (rhlc_ram) with a registered read;
// valid bits are flip-flops. Each transaction makes one scan pass over all N
// entries (N = MAX_OPEN_REGIONS); an absent or failed open ends there, and a
// hit or an insert adds a second read-modify-write pass to age the ranks and
// a write of the entry. The RAM read port gives one entry per cycle per pass.
// A finished result sits in an output register; the block accepts the next
// request while it waits, and stalls only at the end of that request if the
// register is still full. rsp_tvalid holds until rsp_tready.
// Reset (synchronous, active high) clears all valid bits and the control
// state; there is no clearing pass, so the block is ready the cycle after.
`default_nettype none

module region_handle_lru_cache #(
   parameter int MAX_OPEN_REGIONS = rhlc_pkg::DEF_MAX_OPEN_REGIONS,
   parameter int REGION_SHIFT     = rhlc_pkg::DEF_REGION_SHIFT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata, low bit up: chunk_x[22], chunk_z[22], open_outcome[3], zero[1]
   input  wire logic [rhlc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata, low bit up: status[3], slot[4], local_x[5], local_z[5],
   // evicted[1], evicted_region_x[17], evicted_region_z[17], zero[4]
   output logic      [rhlc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready
);

   import rhlc_pkg::*;

   localparam int IDX_W = $clog2(MAX_OPEN_REGIONS);
   localparam int KEY_W = COORD_W - REGION_SHIFT;
   localparam int MEM_W = 2 * KEY_W + IDX_W;
   localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(MAX_OPEN_REGIONS - 1);
   localparam logic [COORD_W-1:0] LOC_MASK = COORD_W'((1 << REGION_SHIFT) - 1);

   // request fields
   logic signed [COORD_W-1:0] req_cx;
   logic signed [COORD_W-1:0] req_cz;
   logic [OUTCOME_W-1:0]      req_outcome;
   logic                      req_fire;

   assign req_cx      = req_tdata[COORD_W-1:0];
   assign req_cz      = req_tdata[2*COORD_W-1:COORD_W];
   assign req_outcome = req_tdata[2*COORD_W+OUTCOME_W-1:2*COORD_W];
   assign req_fire    = req_tvalid && req_tready;

   // control
   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       cnt_ff, cnt_in;
   logic                   rd_vld_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [MAX_OPEN_REGIONS-1:0] valid_ff, valid_in;

   // current transaction
   logic signed [KEY_W-1:0] kx_ff, kz_ff;
   logic [LOC_OUT_W-1:0]    locx_ff, locz_ff;
   logic [OUTCOME_W-1:0]    outcome_ff;

   // scan results
   logic                    hit_ff, hit_in;
   logic [IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]        hit_rec_ff, hit_rec_in;
   logic                    free_ff, free_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]        old_rec_ff, old_rec_in;
   logic [IDX_W-1:0]        old_idx_ff, old_idx_in;
   logic signed [KEY_W-1:0] old_kx_ff, old_kx_in, old_kz_ff, old_kz_in;

   // decision
   logic                    insert_ff, insert_in;
   logic [IDX_W-1:0]        tgt_ff, tgt_in;
   logic [IDX_W-1:0]        age_ff, age_in;
   logic [STATUS_W-1:0]     sts_ff, sts_in;
   logic                    ev_ff, ev_in;
   logic signed [KEY_OUT_W-1:0] evx_ff, evx_in, evz_ff, evz_in;
   logic                    upd_go;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [MEM_W-1:0]        wr_data;
   logic                    rd_en;
   logic [MEM_W-1:0]        rd_data;

   logic signed [KEY_W-1:0] d_kx, d_kz;
   logic [IDX_W-1:0]        d_rec, rec_inc;
   logic                    e_vld;

   assign d_kx    = rd_data[MEM_W-1 -: KEY_W];
   assign d_kz    = rd_data[IDX_W +: KEY_W];
   assign d_rec   = rd_data[IDX_W-1:0];
   assign rec_inc = d_rec + IDX_W'(1);
   assign e_vld   = valid_ff[rd_idx_ff];

   rhlc_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MAX_OPEN_REGIONS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rec_in   = hit_rec_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_rec_in   = old_rec_ff;
      old_idx_in   = old_idx_ff;
      old_kx_in    = old_kx_ff;
      old_kz_in    = old_kz_ff;
      insert_in    = insert_ff;
      tgt_in       = tgt_ff;
      age_in       = age_ff;
      sts_in       = sts_ff;
      ev_in        = ev_ff;
      evx_in       = evx_ff;
      evz_in       = evz_ff;
      upd_go       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = rd_idx_ff;
      wr_data      = {d_kx, d_kz, rec_inc};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hit_in   = 1'b0;
               free_in  = 1'b0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN, ST_SCAN_END: begin
            if (state_ff == ST_SCAN) begin
               rd_en = 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_in = ST_SCAN_END;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end else begin
               state_in = ST_DECIDE;
            end
            if (rd_vld_ff) begin
               // keep the first matching entry
               if (!hit_ff && e_vld && d_kx == kx_ff && d_kz == kz_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_rec_in = d_rec;
               end
               if (!free_ff && !e_vld) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               // victim: largest rank, lowest index on a tie, entry 0 by default
               if (rd_idx_ff == '0 || (e_vld && d_rec > old_rec_ff)) begin
                  old_rec_in = d_rec;
                  old_idx_in = rd_idx_ff;
                  old_kx_in  = d_kx;
                  old_kz_in  = d_kz;
               end
            end
         end
         ST_DECIDE: begin
            insert_in = 1'b0;
            tgt_in    = '0;
            age_in    = hit_rec_ff;
            ev_in     = 1'b0;
            evx_in    = '0;
            evz_in    = '0;
            if (hit_ff) begin
               sts_in = STS_HIT;
               tgt_in = hit_idx_ff;
               upd_go = 1'b1;
            end else begin
               unique case (outcome_ff)
                  OC_OPENED: begin
                     sts_in    = STS_OPENED;
                     insert_in = 1'b1;
                     upd_go    = 1'b1;
                     if (free_ff) begin
                        tgt_in = free_idx_ff;
                     end else begin
                        tgt_in = old_idx_ff;
                        ev_in  = 1'b1;
                        evx_in = KEY_OUT_W'(old_kx_ff);
                        evz_in = KEY_OUT_W'(old_kz_ff);
                     end
                  end
                  OC_ABSENT:  sts_in = STS_ABSENT;
                  OC_NO_OPEN: sts_in = STS_NO_OPEN;
                  OC_CORRUPT: sts_in = STS_CORRUPT;
                  default:    sts_in = STS_IO_ERR;
               endcase
            end
            cnt_in   = '0;
            state_in = upd_go ? ST_UPDATE : ST_DONE;
         end
         ST_UPDATE, ST_UPDATE_END: begin
            if (state_ff == ST_UPDATE) begin
               rd_en = 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_in = ST_UPDATE_END;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end else begin
               state_in = ST_WRITE;
            end
            // age the entries younger than the touched one, or every other entry on an insert
            if (rd_vld_ff && e_vld && rd_idx_ff != tgt_ff &&
                (insert_ff || d_rec < age_ff)) begin
               wr_en = 1'b1;
            end
         end
         ST_WRITE: begin
            wr_en            = 1'b1;
            wr_addr          = tgt_ff;
            wr_data          = {kx_ff, kz_ff, IDX_W'(0)};
            valid_in[tgt_ff] = 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, evz_ff, evx_ff, ev_ff, locz_ff, locx_ff,
                               SLOT_OUT_W'(tgt_ff), sts_ff};
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kx_ff      <= KEY_W'(req_cx >>> REGION_SHIFT);
         kz_ff      <= KEY_W'(req_cz >>> REGION_SHIFT);
         locx_ff    <= LOC_OUT_W'(req_cx & LOC_MASK);
         locz_ff    <= LOC_OUT_W'(req_cz & LOC_MASK);
         outcome_ff <= req_outcome;
      end
      rd_idx_ff   <= cnt_ff;
      cnt_ff      <= cnt_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rec_ff  <= hit_rec_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      old_rec_ff  <= old_rec_in;
      old_idx_ff  <= old_idx_in;
      old_kx_ff   <= old_kx_in;
      old_kz_ff   <= old_kz_in;
      insert_ff   <= insert_in;
      tgt_ff      <= tgt_in;
      age_ff      <= age_in;
      sts_ff      <= sts_in;
      ev_ff       <= ev_in;
      evx_ff      <= evx_in;
      evz_ff      <= evz_in;
      rsp_data_ff <= rsp_data_in;
   end

`include "region_handle_lru_cache_assert.svh"

   `RHLC_ASSERT_NEXT(a_accept_starts_scan, clock, reset, req_fire, state_ff == ST_SCAN)
   `RHLC_ASSERT_NOW(a_age_skips_target, clock, reset,
      wr_en && (state_ff == ST_UPDATE || state_ff == ST_UPDATE_END), rd_idx_ff != tgt_ff)
   `RHLC_ASSERT_NEXT(a_done_waits_on_stall, clock, reset,
      state_ff == ST_DONE && rsp_valid_ff && !rsp_tready, state_ff == ST_DONE)
   `RHLC_ASSERT_NOW(a_evict_only_when_full, clock, reset,
      state_ff == ST_WRITE && ev_ff, &valid_ff)

endmodule

`default_nettype wire

>>> hdl/rhlc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rhlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for region_handle_lru_cache: streams chunk coordinate
// requests through req_*, predicts every response with an LRU table of its own
// and checks rsp_* field by field. Depends on rhlc_pkg and the block's RTL.
module tb_top;
   import rhlc_pkg::*;

   localparam int N_SLOTS      = DEF_MAX_OPEN_REGIONS;
   localparam int SHIFT        = DEF_REGION_SHIFT;
   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 11;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 80;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 484;
   localparam logic [OUTCOME_W-1:0] OC_OTHER = 3'd4;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cz;
      logic [OUTCOME_W-1:0]      outcome;
      int unsigned               idle_pct;
      int unsigned               stall_pct;
      bit                        drain;
   } chunk_req_t;

   typedef struct packed {
      logic [STATUS_W-1:0]          status;
      logic [SLOT_OUT_W-1:0]        slot;
      logic [LOC_OUT_W-1:0]         lx;
      logic [LOC_OUT_W-1:0]         lz;
      logic                         evicted;
      logic signed [KEY_OUT_W-1:0]  evx;
      logic signed [KEY_OUT_W-1:0]  evz;
   } region_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;

   region_handle_lru_cache uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #HALF_PERIOD clock = ~clock;

   // predicted table contents
   bit                          region_live [N_SLOTS];
   logic signed [KEY_OUT_W-1:0] region_kx   [N_SLOTS];
   logic signed [KEY_OUT_W-1:0] region_kz   [N_SLOTS];
   int unsigned                 region_age  [N_SLOTS];

   chunk_req_t  pending_q[$];
   region_rsp_t expected_rsp_q[$];
   logic signed [KEY_OUT_W-1:0] pool_kx[$];
   logic signed [KEY_OUT_W-1:0] pool_kz[$];

   chunk_req_t  offer;
   int unsigned sent_count = 0;
   int unsigned taken_count = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;
   int          err_count = 0;

   // Make slot s the newest; live entries younger than limit age by one.
   function automatic void age_bump(int s, int unsigned limit);
      for (int i = 0; i < N_SLOTS; i++)
         if (region_live[i] && i != s && region_age[i] < limit)
            region_age[i]++;
      region_age[s] = 0;
   endfunction

   function automatic region_rsp_t lookup_region(chunk_req_t r);
      region_rsp_t res;
      logic signed [KEY_OUT_W-1:0] kx;
      logic signed [KEY_OUT_W-1:0] kz;
      int target;
      int unsigned oldest;
      kx = KEY_OUT_W'($signed(r.cx) >>> SHIFT);
      kz = KEY_OUT_W'($signed(r.cz) >>> SHIFT);
      res = '0;
      res.lx = r.cx[LOC_OUT_W-1:0];
      res.lz = r.cz[LOC_OUT_W-1:0];
      target = -1;
      for (int i = 0; i < N_SLOTS; i++)
         if (target < 0 && region_live[i] && region_kx[i] == kx && region_kz[i] == kz)
            target = i;
      if (target >= 0) begin
         age_bump(target, region_age[target]);
         res.status = STS_HIT;
         res.slot = SLOT_OUT_W'(target);
      end else if (r.outcome == OC_OPENED) begin
         // lowest free slot first
         for (int i = N_SLOTS - 1; i >= 0; i--)
            if (!region_live[i])
               target = i;
         if (target < 0) begin
            // table full: oldest entry goes, lowest index on a tie
            oldest = 0;
            target = 0;
            for (int i = 0; i < N_SLOTS; i++)
               if (region_age[i] > oldest) begin
                  oldest = region_age[i];
                  target = i;
               end
            res.evicted = 1'b1;
            res.evx = region_kx[target];
            res.evz = region_kz[target];
         end
         age_bump(target, N_SLOTS);
         region_live[target] = 1'b1;
         region_kx[target] = kx;
         region_kz[target] = kz;
         res.status = STS_OPENED;
         res.slot = SLOT_OUT_W'(target);
      end else begin
         case (r.outcome)
            OC_ABSENT:  res.status = STS_ABSENT;
            OC_NO_OPEN: res.status = STS_NO_OPEN;
            OC_CORRUPT: res.status = STS_CORRUPT;
            default:    res.status = STS_IO_ERR;
         endcase
      end
      return res;
   endfunction

   task automatic queue_req(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cz,
                            logic [OUTCOME_W-1:0] oc, int unsigned idle,
                            int unsigned stall, bit drain);
      chunk_req_t r;
      r.cx = cx;
      r.cz = cz;
      r.outcome = oc;
      r.idle_pct = idle;
      r.stall_pct = stall;
      r.drain = drain;
      pending_q.push_back(r);
   endtask

   // Region keys that the random part revisits; more keys than slots forces evictions.
   task automatic refill_pool(int count);
      logic signed [KEY_OUT_W-1:0] k;
      pool_kx.delete();
      pool_kz.delete();
      for (int i = 0; i < count; i++) begin
         k = ($urandom_range(2) == 0) ? KEY_OUT_W'(int'($urandom_range(7)) - 4)
                                      : KEY_OUT_W'($urandom);
         pool_kx.push_back(k);
         k = ($urandom_range(2) == 0) ? KEY_OUT_W'(int'($urandom_range(7)) - 4)
                                      : KEY_OUT_W'($urandom);
         pool_kz.push_back(k);
      end
   endtask

   task automatic queue_random(int unsigned idle, int unsigned stall, bit drain);
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cz;
      logic [OUTCOME_W-1:0] oc;
      logic [LOC_OUT_W-1:0] ox;
      logic [LOC_OUT_W-1:0] oz;
      int pick;
      ox = LOC_OUT_W'($urandom);
      oz = LOC_OUT_W'($urandom);
      if ($urandom_range(99) < 85) begin
         pick = $urandom_range(pool_kx.size() - 1);
         cx = {pool_kx[pick], ox};
         cz = {pool_kz[pick], oz};
      end else begin
         cx = COORD_W'($urandom);
         cz = COORD_W'($urandom);
      end
      oc = ($urandom_range(99) < 65) ? OC_OPENED : OUTCOME_W'($urandom_range(7));
      queue_req(cx, cz, oc, idle, stall, drain);
   endtask

   // request driver: accept at the rising edge, present at the falling edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_rsp_q.push_back(lookup_region(offer));
         taken_count++;
      end
   end

   always @(negedge clock) begin
      if (!reset && sent_count == taken_count) begin
         // a drain item holds until every outstanding response is back
         if (pending_q.size() > 0 && !(pending_q[0].drain && expected_rsp_q.size() > 0) &&
             $urandom_range(99) >= pending_q[0].idle_pct) begin
            offer = pending_q.pop_front();
            stall_pct = offer.stall_pct;
            sent_count++;
            req_tdata <= {1'b0, offer.outcome, offer.cz, offer.cx};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      region_rsp_t want;
      region_rsp_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status  = rsp_tdata[2:0];
         got.slot    = rsp_tdata[6:3];
         got.lx      = rsp_tdata[11:7];
         got.lz      = rsp_tdata[16:12];
         got.evicted = rsp_tdata[17];
         got.evx     = rsp_tdata[34:18];
         got.evz     = rsp_tdata[51:35];
         if (expected_rsp_q.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("unexpected transaction on rsp: tdata=%h", rsp_tdata);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.lx !== want.lx || got.lz !== want.lz ||
                got.evicted !== want.evicted || got.evx !== want.evx ||
                got.evz !== want.evz) begin
               err_count++;
               if (err_count <= MAX_REPORTS)
                  $display("mismatch: expected sts=%0d slot=%0d loc=%0d,%0d ev=%0b key=%0d,%0d",
                           want.status, want.slot, want.lx, want.lz, want.evicted,
                           want.evx, want.evz,
                           " got sts=%0d slot=%0d loc=%0d,%0d ev=%0b key=%0d,%0d",
                           got.status, got.slot, got.lx, got.lz,
                           got.evicted, got.evx, got.evz);
            end
         end
      end
   end

   // end the run when no transaction moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run
      int unsigned idle;
      int unsigned stall;
      int pool_count;

      // directed: field extremes, every outcome on a miss, hits that ignore the outcome
      queue_req(0, 0, OC_OPENED, 0, 0, 0);
      queue_req(31, 31, OC_CORRUPT, 0, 0, 0);
      queue_req(-1, -1, OC_ABSENT, 0, 0, 0);
      queue_req(2097151, -2097152, OC_NO_OPEN, 0, 0, 0);
      queue_req(-2097152, 2097151, OC_CORRUPT, 0, 0, 0);
      queue_req(-33, 64, OC_OTHER, 0, 0, 0);
      queue_req(100, -100, 3'd5, 0, 0, 0);
      queue_req(-5000, 5000, 3'd6, 0, 0, 0);
      queue_req(123456, -654321, 3'd7, 0, 0, 0);
      queue_req(-1, -1, OC_OPENED, 0, 0, 0);
      queue_req(-32, -1, OC_ABSENT, 0, 0, 0);
      queue_req(2097151, 2097151, OC_OPENED, 0, 0, 0);
      queue_req(-2097152, -2097152, OC_OPENED, 0, 0, 0);
      queue_req(0, 32, OC_OPENED, 0, 0, 0);
      queue_req(32, 0, OC_OPENED, 0, 0, 0);
      queue_req(0, 0, OC_OPENED, 0, 0, 0);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle = 0;  stall = 0;  pool_count = 12; end
            1: begin idle = 82; stall = 0;  pool_count = 24; end
            2: begin idle = 0;  stall = 82; pool_count = 17; end
            default: begin idle = 31; stall = 31; pool_count = 40; end
         endcase
         refill_pool(pool_count);
         for (int n = 0; n < PHASE_ITEMS; n++)
            queue_random(idle, stall, n == 0);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || sent_count != taken_count ||
             expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_count == 0 && expected_rsp_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
